/* hw/rtl/hsi_pkg.sv */
package hsi_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int DIV_STEPS    = 16;
  localparam int XW           = 37;
  localparam int ZW           = 32;

  localparam logic [14:0] HUE_FULL = 15'd23040;
  localparam logic [14:0] HUE_GRAY = 15'd5760;
  localparam logic [15:0] SAT_ONE  = 16'd32768;
  localparam logic [24:0] SQRT3_Q24 = 25'd29058991;
  localparam logic [17:0] INV3     = 18'd174763;
  localparam logic signed [ZW-1:0] ANG_90  = 32'sd377487360;
  localparam logic signed [ZW-1:0] ANG_180 = 32'sd754974720;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsi_pixel_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [15:0] intensity;
  } hsi_result_t;

  typedef struct packed {
    logic                 vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [10:0]          rem;
    logic [10:0]          den;
    logic [15:0]          nlo;
    logic [15:0]          quo;
    logic                 sat_zero;
    logic                 sat_one;
    logic                 gray;
    logic                 flip;
    logic [15:0]          inten;
  } hsi_stage_t;

  function automatic logic signed [ZW-1:0] atan_angle(input int unsigned k);
    case (k)
      0:  atan_angle = 32'sd188743680;
      1:  atan_angle = 32'sd111421900;
      2:  atan_angle = 32'sd58872272;
      3:  atan_angle = 32'sd29884485;
      4:  atan_angle = 32'sd15000234;
      5:  atan_angle = 32'sd7507429;
      6:  atan_angle = 32'sd3754631;
      7:  atan_angle = 32'sd1877430;
      8:  atan_angle = 32'sd938729;
      9:  atan_angle = 32'sd469366;
      10: atan_angle = 32'sd234683;
      11: atan_angle = 32'sd117342;
      12: atan_angle = 32'sd58671;
      13: atan_angle = 32'sd29335;
      14: atan_angle = 32'sd14668;
      15: atan_angle = 32'sd7334;
      16: atan_angle = 32'sd3667;
      17: atan_angle = 32'sd1833;
      18: atan_angle = 32'sd917;
      19: atan_angle = 32'sd458;
      20: atan_angle = 32'sd229;
      21: atan_angle = 32'sd115;
      22: atan_angle = 32'sd57;
      23: atan_angle = 32'sd29;
      default: atan_angle = 32'sd0;
    endcase
  endfunction

endpackage

/* hw/rtl/hsi_prep.sv */
module hsi_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               pixel_valid,
  input  hsi_pkg::hsi_pixel_t pixel,
  output hsi_pkg::hsi_stage_t st_out
);
  import hsi_pkg::*;

  logic [9:0]           s;
  logic [7:0]           m;
  logic [9:0]           p;
  logic [17:0]          v;
  logic signed [10:0]   num;
  logic [7:0]           gb;
  logic [26:0]          p_big;

  logic                 a_vld;
  logic signed [XW-1:0] a_x;
  logic signed [XW-1:0] a_y;
  logic [9:0]           a_s;
  logic [9:0]           a_p;
  logic [15:0]          a_inten;
  logic                 a_zero;
  logic                 a_one;
  logic                 a_gray;
  logic                 a_flip;

  hsi_stage_t           b_next;

  always_comb begin
    s = 10'(pixel.red) + 10'(pixel.green) + 10'(pixel.blue);
    m = (pixel.red < pixel.green) ? pixel.red : pixel.green;
    if (pixel.blue < m) begin
      m = pixel.blue;
    end
    p = s - ({1'b0, m, 1'b0} + {2'b00, m});
    v = 18'(s) * 18'd257 + 18'd1;
    num = $signed({2'b00, pixel.red, 1'b0}) - $signed({3'b000, pixel.green})
        - $signed({3'b000, pixel.blue});
    gb = (pixel.green > pixel.blue) ? pixel.green - pixel.blue
                                    : pixel.blue - pixel.green;
    p_big = 27'(p) * 27'd100000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld   <= pixel_valid;
      a_x     <= {{(XW-35){num[10]}}, num, 24'd0};
      a_y     <= $signed({{(XW-33){1'b0}}, 33'(33'(gb) * 33'(SQRT3_Q24))});
      a_s     <= s;
      a_p     <= p;
      a_inten <= 16'((36'(v) * 36'(INV3)) >> 19);
      a_zero  <= (s == 10'd0) || (p_big < 27'(s));
      a_one   <= p_big > 27'(s) * 27'd99999;
      a_gray  <= (pixel.red == pixel.green) && (pixel.green == pixel.blue);
      a_flip  <= pixel.blue > pixel.green;
    end
  end

  always_comb begin
    b_next.vld = a_vld;
    if (a_x < 0) begin
      b_next.x = a_y;
      b_next.y = -a_x;
      b_next.z = ANG_90;
    end else begin
      b_next.x = a_x;
      b_next.y = a_y;
      b_next.z = '0;
    end
    b_next.rem      = 11'(a_p);
    b_next.den      = {a_s, 1'b0};
    b_next.nlo      = 16'(a_s);
    b_next.quo      = '0;
    b_next.sat_zero = a_zero;
    b_next.sat_one  = a_one;
    b_next.gray     = a_gray;
    b_next.flip     = a_flip;
    b_next.inten    = a_inten;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_out.vld <= 1'b0;
    end else if (en) begin
      st_out <= b_next;
    end
  end

endmodule

/* hw/rtl/hsi_core.sv */
module hsi_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  hsi_pkg::hsi_stage_t st_in,
  output hsi_pkg::hsi_stage_t st_out
);
  import hsi_pkg::*;

  hsi_stage_t st [CORDIC_STEPS:0];

  assign st[0] = st_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [XW-1:0] RND = XW'((64'd1 << i) - 64'd1);
    logic signed [XW-1:0] xsum;
    logic signed [XW-1:0] ysum;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic [11:0]          r2;
    hsi_stage_t           nxt;

    always_comb begin
      nxt  = st[i];
      xsum = st[i].x + (st[i].x[XW-1] ? RND : '0);
      ysum = st[i].y + (st[i].y[XW-1] ? RND : '0);
      xs   = xsum >>> i;
      ys   = ysum >>> i;
      if (!st[i].y[XW-1]) begin
        nxt.x = st[i].x + ys;
        nxt.y = st[i].y - xs;
        nxt.z = st[i].z + atan_angle(i);
      end else begin
        nxt.x = st[i].x - ys;
        nxt.y = st[i].y + xs;
        nxt.z = st[i].z - atan_angle(i);
      end
      r2 = {st[i].rem, st[i].nlo[15]};
      if (i < DIV_STEPS) begin
        nxt.nlo = {st[i].nlo[14:0], 1'b0};
        if (r2 >= {1'b0, st[i].den}) begin
          nxt.rem = 11'(r2 - {1'b0, st[i].den});
          nxt.quo = {st[i].quo[14:0], 1'b1};
        end else begin
          nxt.rem = r2[10:0];
          nxt.quo = {st[i].quo[14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1].vld <= 1'b0;
      end else if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign st_out = st[CORDIC_STEPS];

endmodule

/* hw/rtl/hsi_final.sv */
module hsi_final (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  hsi_pkg::hsi_stage_t  st_in,
  output logic                 hsi_valid,
  output hsi_pkg::hsi_result_t hsi
);
  import hsi_pkg::*;

  logic signed [ZW-1:0] zc;
  logic [14:0]          th;
  hsi_result_t          res_next;

  always_comb begin
    zc = st_in.z;
    if (zc < 0) begin
      zc = '0;
    end
    if (zc > ANG_180) begin
      zc = ANG_180;
    end
    th = 15'((zc + 32'sd32768) >>> 16);
    if (st_in.gray) begin
      res_next.hue = HUE_GRAY;
    end else if (st_in.flip) begin
      res_next.hue = HUE_FULL - th;
    end else begin
      res_next.hue = th;
    end
    if (st_in.sat_zero) begin
      res_next.saturation = '0;
    end else if (st_in.sat_one) begin
      res_next.saturation = SAT_ONE;
    end else begin
      res_next.saturation = st_in.quo;
    end
    res_next.intensity = st_in.inten;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsi_valid <= 1'b0;
    end else if (en) begin
      hsi_valid <= st_in.vld;
      hsi       <= res_next;
    end
  end

endmodule

/* hw/rtl/rgb_to_hsi_pixel_top.sv */
// Throughput is one pixel per cycle unless the result word is stalled; the 24-stage CORDIC pipeline sets the depth.
// The whole pipeline advances together and holds while the result word is not taken.
// Reset is synchronous and clears only the valid bits of every stage.
module rgb_to_hsi_pixel_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_ready,
  input  hsi_pkg::hsi_pixel_t  pixel,
  output logic                 hsi_valid,
  input  logic                 hsi_ready,
  output hsi_pkg::hsi_result_t hsi
);
  import hsi_pkg::*;

  logic       en;
  hsi_stage_t st_prep;
  hsi_stage_t st_core;

  assign en          = !hsi_valid || hsi_ready;
  assign pixel_ready = en;

  hsi_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .st_out      (st_prep)
  );

  hsi_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .st_in  (st_prep),
    .st_out (st_core)
  );

  hsi_final u_final (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .st_in     (st_core),
    .hsi_valid (hsi_valid),
    .hsi       (hsi)
  );

`ifndef SYNTH
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    hsi_valid |-> hsi.saturation <= SAT_ONE)
    else $error("Saturation above one.");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsi_valid |-> hsi.hue <= HUE_FULL)
    else $error("Hue above full circle.");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (hsi_valid && hsi.intensity == 16'd0) |->
      (hsi.saturation == 16'd0 && hsi.hue == HUE_GRAY))
    else $error("Black pixel gives a wrong word.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (hsi_valid && !hsi_ready) |=> hsi_valid)
    else $error("Result word dropped while stalled.");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import hsi_pkg::*;

  logic        clk;
  logic        rst;
  logic        pixel_valid;
  logic        pixel_ready;
  hsi_pixel_t  pixel;
  logic        hsi_valid;
  logic        hsi_ready;
  hsi_result_t hsi;

  hsi_pixel_t  pending_pixels[$];
  hsi_result_t expected_hsi[$];
  int          mismatch_count;
  int          cycle_count;
  int          send_wait;
  int          take_wait;

  localparam int CYCLE_LIMIT = 200000;

  rgb_to_hsi_pixel_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .hsi_valid   (hsi_valid),
    .hsi_ready   (hsi_ready),
    .hsi         (hsi)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic longint unsigned shift_toward_zero(longint v, int k);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    mag = mag >> k;
    return mag;
  endfunction

  function automatic longint shift_signed(longint v, int k);
    longint m;
    m = longint'(shift_toward_zero(v, k));
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [14:0] cordic_hue(longint num, longint gb_mag);
    longint x;
    longint y;
    longint z;
    longint t;
    longint xs;
    longint ys;
    x = num * (longint'(1) << 24);
    y = gb_mag * longint'(SQRT3_Q24);
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = longint'(ANG_90);
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = shift_signed(x, i);
      ys = shift_signed(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_angle(i));
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_angle(i));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(ANG_180)) z = longint'(ANG_180);
    return 15'((z + 32768) >>> 16);
  endfunction

  function automatic hsi_result_t convert_pixel(hsi_pixel_t p);
    hsi_result_t res;
    longint r;
    longint g;
    longint b;
    longint s;
    longint m;
    longint q;
    longint gb;
    logic [14:0] angle;
    r = p.red;
    g = p.green;
    b = p.blue;
    s = r + g + b;
    m = (r < g) ? r : g;
    if (b < m) m = b;
    res.intensity = 16'((s * 257 + 1) / 3);
    if (s == 0) begin
      res.saturation = '0;
    end else begin
      q = s - 3 * m;
      res.saturation = 16'((65536 * q + s) / (2 * s));
      if (100000 * q < s) res.saturation = '0;
      else if (100000 * q > 99999 * s) res.saturation = SAT_ONE;
    end
    if (r == g && g == b) begin
      res.hue = HUE_GRAY;
    end else begin
      gb = g - b;
      if (gb < 0) gb = -gb;
      angle = cordic_hue(2 * r - g - b, gb);
      res.hue = (b > g) ? HUE_FULL - angle : angle;
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("Mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatch_count++;
  endtask

  task automatic queue_pixel(int r, int g, int b);
    hsi_pixel_t p;
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    pending_pixels.push_back(p);
  endtask

  initial begin
    int base;
    mismatch_count = 0;
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(128, 128, 128);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 255, 0);
    queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 255);
    queue_pixel(1, 0, 0);
    queue_pixel(0, 0, 1);
    queue_pixel(0, 1, 0);
    queue_pixel(255, 254, 255);
    queue_pixel(255, 255, 254);
    queue_pixel(254, 255, 255);
    queue_pixel(0, 255, 254);
    queue_pixel(0, 254, 255);
    queue_pixel(170, 85, 0);
    queue_pixel(85, 170, 255);
    queue_pixel(100, 100, 101);
    for (int n = 0; n < 1330; n++) begin
      case ($urandom_range(0, 3))
        0: queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
        1: begin
          base = $urandom_range(0, 253);
          queue_pixel(base + $urandom_range(0, 2), base + $urandom_range(0, 2),
                      base + $urandom_range(0, 2));
        end
        2: begin
          base = $urandom_range(0, 255);
          queue_pixel(base, base, $urandom_range(0, 255));
        end
        default: queue_pixel($urandom_range(0, 1) * 255, $urandom_range(0, 255),
                             $urandom_range(0, 1) * 255);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      pixel <= '0;
      send_wait <= $urandom_range(0, 17);
    end else if (!pixel_valid || pixel_ready) begin
      if (pixel_valid) expected_hsi.push_back(convert_pixel(pixel));
      if (send_wait > 0 || pending_pixels.size() == 0) begin
        pixel_valid <= 1'b0;
        if (send_wait > 0) send_wait <= send_wait - 1;
      end else begin
        pixel <= pending_pixels.pop_front();
        pixel_valid <= 1'b1;
        send_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
      end
    end
  end

  always @(posedge clk) begin
    hsi_result_t want;
    int          next_wait;
    if (rst) begin
      hsi_ready <= 1'b0;
      take_wait <= $urandom_range(0, 17);
    end else begin
      if (hsi_valid && hsi_ready) begin
        if (expected_hsi.size() == 0) begin
          $display("Result word arrived with none expected");
          mismatch_count++;
        end else begin
          want = expected_hsi.pop_front();
          if (hsi.hue !== want.hue) report_mismatch("hue", hsi.hue, want.hue);
          if (hsi.saturation !== want.saturation)
            report_mismatch("saturation", hsi.saturation, want.saturation);
          if (hsi.intensity !== want.intensity)
            report_mismatch("intensity", hsi.intensity, want.intensity);
        end
        next_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
        take_wait <= next_wait;
        hsi_ready <= (next_wait == 0);
      end else if (take_wait > 0) begin
        take_wait <= take_wait - 1;
        hsi_ready <= 1'b0;
      end else begin
        hsi_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    pixel_valid = 1'b0;
    pixel = '0;
    hsi_ready = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait (pending_pixels.size() == 0 && !pixel_valid);
    wait (expected_hsi.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* rgb_to_hsi_pixel_top.f */
hw/rtl/hsi_pkg.sv
hw/rtl/hsi_prep.sv
hw/rtl/hsi_core.sv
hw/rtl/hsi_final.sv
hw/rtl/rgb_to_hsi_pixel_top.sv
tb/sv/testbench.sv
